FILE: src/hsv_chroma_key_pixel_assert.svh
// Assertion macros shared by the chroma key checker.
`ifndef HSV_CHROMA_KEY_PIXEL_ASSERT_SVH
`define HSV_CHROMA_KEY_PIXEL_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HCK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define HCK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hck_pkg.sv
// Shared constants, codes and types of the HSV chroma key pipeline.
package hck_pkg;

  localparam int PIX_W = 8;
  localparam int NUM_W = 2 * PIX_W;

  localparam int HUE_SECTOR = 42;
  localparam int HUE_HALF   = 126;
  localparam int HUE_FULL   = 252;
  localparam int FULL_SCALE = 255;

  // Pipeline layout: two front stages, one divider stage per quotient bit,
  // two stages for hue assembly and the key decision.
  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = PIX_W;
  localparam int MATCH_STAGES = 2;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + MATCH_STAGES;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HUE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_VAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_TOL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_TOL  = 3'd5;

  localparam logic [PIX_W-1:0] RST_KEY_HUE = 8'd84;
  localparam logic [PIX_W-1:0] RST_KEY_SAT = 8'd255;
  localparam logic [PIX_W-1:0] RST_KEY_VAL = 8'd255;
  localparam logic [PIX_W-1:0] RST_TOL     = 8'd0;

  // Which component was taken as the minimum; sets the hue sector.
  localparam logic [1:0] SECT_RED_MIN   = 2'd0;
  localparam logic [1:0] SECT_BLUE_MIN  = 2'd1;
  localparam logic [1:0] SECT_GREEN_MIN = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] back_red;
    logic [PIX_W-1:0] back_green;
    logic [PIX_W-1:0] back_blue;
  } pix_pair_t;

  typedef struct packed {
    pix_pair_t        pix;
    logic [PIX_W-1:0] val;
    logic [1:0]       sector;
    logic             neg;
    logic             grey;
  } hck_side_t;

  typedef struct packed {
    logic [PIX_W-1:0] key_hue;
    logic [PIX_W-1:0] key_sat;
    logic [PIX_W-1:0] key_val;
    logic [PIX_W-1:0] hue_tol;
    logic [PIX_W-1:0] sat_tol;
    logic [PIX_W-1:0] val_tol;
  } key_cfg_t;

endpackage

FILE: src/hsv_chroma_key_pixel.sv
// HSV chroma key top level: config registers, pipeline control and stages.
// The result is held on an output register. Throughput is one item per cycle
// unless out_ready stalls; the eight divider stages set the depth.
// Each stage moves when it is empty or the stage after it moves, so bubbles fill.
// Synchronous active-low reset clears the valid bits and loads register defaults.
module hsv_chroma_key_pixel import hck_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_blue,
  input  logic [PIX_W-1:0]     in_back_red,
  input  logic [PIX_W-1:0]     in_back_green,
  input  logic [PIX_W-1:0]     in_back_blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_red,
  output logic [PIX_W-1:0]     out_green,
  output logic [PIX_W-1:0]     out_blue,
  output logic                 out_keyed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  key_cfg_t               cfg_r;
  logic [NUM_STAGES-1:0]  valid_r;
  logic [NUM_STAGES-1:0]  adv;

  pix_pair_t              pix;
  logic [NUM_W-1:0]       num_h;
  logic [PIX_W-1:0]       den_h;
  logic [NUM_W-1:0]       num_s;
  logic [PIX_W-1:0]       den_s;
  hck_side_t              front_side;
  logic [PIX_W-1:0]       quot_h;
  logic [PIX_W-1:0]       quot_s;
  hck_side_t              div_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_hue <= RST_KEY_HUE;
      cfg_r.key_sat <= RST_KEY_SAT;
      cfg_r.key_val <= RST_KEY_VAL;
      cfg_r.hue_tol <= RST_TOL;
      cfg_r.sat_tol <= RST_TOL;
      cfg_r.val_tol <= RST_TOL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_HUE: cfg_r.key_hue <= cfg_data;
        CFG_KEY_SAT: cfg_r.key_sat <= cfg_data;
        CFG_KEY_VAL: cfg_r.key_val <= cfg_data;
        CFG_HUE_TOL: cfg_r.hue_tol <= cfg_data;
        CFG_SAT_TOL: cfg_r.sat_tol <= cfg_data;
        CFG_VAL_TOL: cfg_r.val_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it holds nothing or its item moves on this cycle.
  assign adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
  for (genvar i = 0; i < NUM_STAGES - 1; i++) begin : g_adv
    assign adv[i] = !valid_r[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) valid_r[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  assign pix.red        = in_red;
  assign pix.green      = in_green;
  assign pix.blue       = in_blue;
  assign pix.back_red   = in_back_red;
  assign pix.back_green = in_back_green;
  assign pix.back_blue  = in_back_blue;

  hck_hsv_front u_front (
    .clk   (clk),
    .en    (adv[FRONT_STAGES-1:0]),
    .pix   (pix),
    .num_h (num_h),
    .den_h (den_h),
    .num_s (num_s),
    .den_s (den_s),
    .side  (front_side)
  );

  hck_div_pipe u_div (
    .clk      (clk),
    .en       (adv[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
    .num_a    (num_h),
    .den_a    (den_h),
    .num_b    (num_s),
    .den_b    (den_s),
    .side_in  (front_side),
    .quot_a   (quot_h),
    .quot_b   (quot_s),
    .side_out (div_side)
  );

  hck_key_match u_match (
    .clk    (clk),
    .en     (adv[NUM_STAGES-1:NUM_STAGES-MATCH_STAGES]),
    .quot_h (quot_h),
    .quot_s (quot_s),
    .side   (div_side),
    .cfg    (cfg_r),
    .red    (out_red),
    .green  (out_green),
    .blue   (out_blue),
    .keyed  (out_keyed)
  );

endmodule

FILE: src/hck_hsv_front.sv
// Front stages: min/max, sector choice, then divider numerators and divisors.
module hck_hsv_front import hck_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  pix_pair_t               pix,
  output logic [NUM_W-1:0]        num_h,
  output logic [PIX_W-1:0]        den_h,
  output logic [NUM_W-1:0]        num_s,
  output logic [PIX_W-1:0]        den_s,
  output hck_side_t               side
);

  logic [PIX_W-1:0] lo;
  logic [PIX_W-1:0] hi;
  logic [PIX_W:0]   diff;
  logic [PIX_W:0]   diff_neg;
  logic [1:0]       sector;

  pix_pair_t        pix0_r;
  logic [PIX_W-1:0] hi0_r;
  logic [PIX_W-1:0] span0_r;
  logic [PIX_W-1:0] mag0_r;
  logic [1:0]       sector0_r;
  logic             neg0_r;
  logic             grey0_r;

  logic [NUM_W-1:0] num_h_r;
  logic [PIX_W-1:0] den_h_r;
  logic [NUM_W-1:0] num_s_r;
  logic [PIX_W-1:0] den_s_r;
  hck_side_t        side_r;

  always_comb begin
    lo = pix.red;
    hi = pix.red;
    if (pix.green < lo) lo = pix.green;
    if (pix.blue < lo) lo = pix.blue;
    if (pix.green > hi) hi = pix.green;
    if (pix.blue > hi) hi = pix.blue;
  end

  // Ties are resolved with red tested as the minimum first, then blue.
  always_comb begin
    if (pix.red == lo) begin
      diff   = {1'b0, pix.green} - {1'b0, pix.blue};
      sector = SECT_RED_MIN;
    end else if (pix.blue == lo) begin
      diff   = {1'b0, pix.red} - {1'b0, pix.green};
      sector = SECT_BLUE_MIN;
    end else begin
      diff   = {1'b0, pix.blue} - {1'b0, pix.red};
      sector = SECT_GREEN_MIN;
    end
    diff_neg = '0 - diff;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix0_r    <= pix;
      hi0_r     <= hi;
      span0_r   <= hi - lo;
      neg0_r    <= diff[PIX_W];
      mag0_r    <= diff[PIX_W] ? diff_neg[PIX_W-1:0] : diff[PIX_W-1:0];
      sector0_r <= sector;
      grey0_r   <= (lo == hi);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_h_r       <= NUM_W'(mag0_r) * NUM_W'(HUE_SECTOR);
      den_h_r       <= span0_r;
      num_s_r       <= NUM_W'(span0_r) * NUM_W'(FULL_SCALE);
      den_s_r       <= hi0_r;
      side_r.pix    <= pix0_r;
      side_r.val    <= hi0_r;
      side_r.sector <= sector0_r;
      side_r.neg    <= neg0_r;
      side_r.grey   <= grey0_r;
    end
  end

  assign num_h = num_h_r;
  assign den_h = den_h_r;
  assign num_s = num_s_r;
  assign den_s = den_s_r;
  assign side  = side_r;

endmodule

FILE: src/hck_div_pipe.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module hck_div_pipe import hck_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num_a,
  input  logic [PIX_W-1:0]      den_a,
  input  logic [NUM_W-1:0]      num_b,
  input  logic [PIX_W-1:0]      den_b,
  input  hck_side_t             side_in,
  output logic [PIX_W-1:0]      quot_a,
  output logic [PIX_W-1:0]      quot_b,
  output hck_side_t             side_out
);

  // The upper half of the work word is the partial remainder, the lower half
  // collects quotient bits as the dividend bits shift out.
  function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
                                                input logic [PIX_W-1:0] d);
    logic [NUM_W:0] sh;
    logic [PIX_W:0] trial;
    sh    = {w, 1'b0};
    trial = sh[NUM_W:PIX_W] - {1'b0, d};
    if (sh[NUM_W:PIX_W] >= {1'b0, d}) begin
      div_step = {trial[PIX_W-1:0], sh[PIX_W-1:1], 1'b1};
    end else begin
      div_step = {sh[NUM_W-1:PIX_W], sh[PIX_W-1:1], 1'b0};
    end
  endfunction

  logic [NUM_W-1:0] work_a_r [DIV_STAGES];
  logic [PIX_W-1:0] den_a_r  [DIV_STAGES];
  logic [NUM_W-1:0] work_b_r [DIV_STAGES];
  logic [PIX_W-1:0] den_b_r  [DIV_STAGES];
  hck_side_t        side_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) begin
          work_a_r[k] <= div_step(num_a, den_a);
          den_a_r[k]  <= den_a;
          work_b_r[k] <= div_step(num_b, den_b);
          den_b_r[k]  <= den_b;
          side_r[k]   <= side_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[k]) begin
          work_a_r[k] <= div_step(work_a_r[k-1], den_a_r[k-1]);
          den_a_r[k]  <= den_a_r[k-1];
          work_b_r[k] <= div_step(work_b_r[k-1], den_b_r[k-1]);
          den_b_r[k]  <= den_b_r[k-1];
          side_r[k]   <= side_r[k-1];
        end
      end
    end
  end

  assign quot_a   = work_a_r[DIV_STAGES-1][PIX_W-1:0];
  assign quot_b   = work_b_r[DIV_STAGES-1][PIX_W-1:0];
  assign side_out = side_r[DIV_STAGES-1];

endmodule

FILE: src/hck_key_match.sv
// Back stages: hue assembly, tolerance tests against the key and pixel select.
module hck_key_match import hck_pkg::*; (
  input  logic                    clk,
  input  logic [MATCH_STAGES-1:0] en,
  input  logic [PIX_W-1:0]        quot_h,
  input  logic [PIX_W-1:0]        quot_s,
  input  hck_side_t               side,
  input  key_cfg_t                cfg,
  output logic [PIX_W-1:0]        red,
  output logic [PIX_W-1:0]        green,
  output logic [PIX_W-1:0]        blue,
  output logic                    keyed
);

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a >= b) ? a - b : b - a;
  endfunction

  logic [PIX_W:0]   base;
  logic [PIX_W:0]   hue_full;
  logic [PIX_W-1:0] hue;
  logic [PIX_W-1:0] hue_sh;

  logic [PIX_W-1:0] hue_r;
  logic [PIX_W-1:0] hue_sh_r;
  logic [PIX_W-1:0] sat_r;
  logic [PIX_W-1:0] val_r;
  pix_pair_t        pix_r;

  logic [PIX_W:0]   key_sh_full;
  logic [PIX_W-1:0] key_sh;
  logic             hit;

  logic [PIX_W-1:0] red_r;
  logic [PIX_W-1:0] green_r;
  logic [PIX_W-1:0] blue_r;
  logic             keyed_r;

  always_comb begin
    case (side.sector)
      SECT_BLUE_MIN:  base = (PIX_W+1)'(1 * HUE_SECTOR);
      SECT_RED_MIN:   base = (PIX_W+1)'(3 * HUE_SECTOR);
      SECT_GREEN_MIN: base = (PIX_W+1)'(5 * HUE_SECTOR);
      default:        base = '0;
    endcase
    // The quotient is of the magnitude; a negative difference adds it back.
    hue_full = side.neg ? base + {1'b0, quot_h} : base - {1'b0, quot_h};
    hue      = side.grey ? '0 : hue_full[PIX_W-1:0];
    // Hue stays below the full circle, so the half turn wraps with one compare.
    hue_sh   = (hue >= PIX_W'(HUE_HALF)) ? hue - PIX_W'(HUE_HALF)
                                          : hue + PIX_W'(HUE_HALF);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hue_r    <= hue;
      hue_sh_r <= hue_sh;
      sat_r    <= side.grey ? '0 : quot_s;
      val_r    <= side.val;
      pix_r    <= side.pix;
    end
  end

  always_comb begin
    key_sh_full = {1'b0, cfg.key_hue} + (PIX_W+1)'(HUE_HALF);
    key_sh      = (key_sh_full >= (PIX_W+1)'(HUE_FULL))
                  ? PIX_W'(key_sh_full - (PIX_W+1)'(HUE_FULL))
                  : key_sh_full[PIX_W-1:0];
    hit = ((abs_diff(hue_r, cfg.key_hue) <= cfg.hue_tol) ||
           (abs_diff(hue_sh_r, key_sh) <= cfg.hue_tol)) &&
          (abs_diff(sat_r, cfg.key_sat) <= cfg.sat_tol) &&
          (abs_diff(val_r, cfg.key_val) <= cfg.val_tol);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      red_r   <= hit ? pix_r.back_red   : pix_r.red;
      green_r <= hit ? pix_r.back_green : pix_r.green;
      blue_r  <= hit ? pix_r.back_blue  : pix_r.blue;
      keyed_r <= hit;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;
  assign keyed = keyed_r;

endmodule

FILE: src/hck_checker.sv
// Port-level checker for the chroma key block, bound to the top level.
`include "hsv_chroma_key_pixel_assert.svh"

module hck_checker import hck_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [PIX_W-1:0]     in_red,
  input logic [PIX_W-1:0]     in_green,
  input logic [PIX_W-1:0]     in_blue,
  input logic [PIX_W-1:0]     in_back_red,
  input logic [PIX_W-1:0]     in_back_green,
  input logic [PIX_W-1:0]     in_back_blue,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIX_W-1:0]     out_red,
  input logic [PIX_W-1:0]     out_green,
  input logic [PIX_W-1:0]     out_blue,
  input logic                 out_keyed,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [PIX_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(NUM_STAGES + 1) + 1;

  // Items accepted at the input and not yet taken at the output.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             in_acc;
  logic             out_acc;
  logic [PIX_W*3:0] out_word;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign out_word = {out_red, out_green, out_blue, out_keyed};

  always_comb begin
    count_nxt = count_r + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `HCK_ASSERT_ALWAYS(a_no_invented_item, !out_valid || (count_r != '0), "result without item")
  `HCK_ASSERT_ALWAYS(a_empty_takes_item, (count_r != '0) || in_ready, "empty block refuses item")
  `HCK_ASSERT_ALWAYS(a_depth_bound, count_r <= CNT_W'(NUM_STAGES), "more items than stages")
  `HCK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind hsv_chroma_key_pixel hck_checker u_hck_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HSV chroma key pixel pipeline.
module tb_top;
  import hck_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 80;
  localparam int PHASE_ITEMS = 144;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             keyed;
  } px_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_red = '0;
  logic [PIX_W-1:0]     in_green = '0;
  logic [PIX_W-1:0]     in_blue = '0;
  logic [PIX_W-1:0]     in_back_red = '0;
  logic [PIX_W-1:0]     in_back_green = '0;
  logic [PIX_W-1:0]     in_back_blue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic                 out_keyed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PIX_W-1:0]     cfg_data = '0;

  pix_pair_t  pending_pix[$];
  px_result_t expected_px[$];
  key_cfg_t   key_set = '{RST_KEY_HUE, RST_KEY_SAT, RST_KEY_VAL, RST_TOL, RST_TOL, RST_TOL};
  pix_pair_t  next_pix;
  px_result_t got_px;
  px_result_t want_px;
  logic       in_fire = 1'b0;
  int         send_idle_pct = 34;
  int         recv_idle_pct = 34;
  bit         stall_request = 1'b0;
  bit         stall_done = 1'b0;
  int         stall_left = 0;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;

  hsv_chroma_key_pixel dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit in_margin(int a, int b, int margin);
    return (a > b ? a - b : b - a) <= margin;
  endfunction

  function automatic void pixel_hsv(input int r, input int g, input int b,
                                    output int hue, output int sat, output int val);
    int lo;
    int hi;
    int delta;
    int sector;
    lo = r;
    hi = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    val = hi;
    if (lo == hi) begin
      hue = 0;
      sat = 0;
    end else begin
      // Red is tried as the minimum first, then blue, so ties land in those sectors.
      if (r == lo) begin
        delta = g - b;
        sector = 3;
      end else if (b == lo) begin
        delta = r - g;
        sector = 1;
      end else begin
        delta = b - r;
        sector = 5;
      end
      hue = sector * HUE_SECTOR - (delta * HUE_SECTOR) / (hi - lo);
      sat = ((hi - lo) * FULL_SCALE) / hi;
    end
  endfunction

  function automatic px_result_t predict_key(pix_pair_t p, key_cfg_t k);
    int hue;
    int sat;
    int val;
    int kh;
    bit hit;
    px_result_t res;
    pixel_hsv(p.red, p.green, p.blue, hue, sat, val);
    kh = int'(k.key_hue);
    // A key hue above 251 is compared as is; only the shifted test wraps it.
    hit = (in_margin(hue, kh, k.hue_tol) ||
           in_margin((hue + HUE_HALF) % HUE_FULL, (kh + HUE_HALF) % HUE_FULL, k.hue_tol)) &&
          in_margin(sat, k.key_sat, k.sat_tol) &&
          in_margin(val, k.key_val, k.val_tol);
    if (hit) res = '{p.back_red, p.back_green, p.back_blue, 1'b1};
    else     res = '{p.red, p.green, p.blue, 1'b0};
    return res;
  endfunction

  function automatic int jitter(int c);
    int j;
    j = c + int'($urandom_range(16)) - 8;
    return j < 0 ? 0 : (j > 255 ? 255 : j);
  endfunction

  task automatic add_pixel(input int r, input int g, input int b,
                           input int br, input int bg, input int bb);
    pix_pair_t p;
    p = '{r[7:0], g[7:0], b[7:0], br[7:0], bg[7:0], bb[7:0]};
    pending_pix.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_HUE: key_set.key_hue = data;
      CFG_KEY_SAT: key_set.key_sat = data;
      CFG_KEY_VAL: key_set.key_val = data;
      CFG_HUE_TOL: key_set.hue_tol = data;
      CFG_SAT_TOL: key_set.sat_tol = data;
      CFG_VAL_TOL: key_set.val_tol = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_key(input int kh, input int ks, input int kv,
                             input int ht, input int st, input int vt);
    write_reg(CFG_KEY_HUE, kh[7:0]);
    write_reg(CFG_KEY_SAT, ks[7:0]);
    write_reg(CFG_KEY_VAL, kv[7:0]);
    write_reg(CFG_HUE_TOL, ht[7:0]);
    write_reg(CFG_SAT_TOL, st[7:0]);
    write_reg(CFG_VAL_TOL, vt[7:0]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pix.size() != 0 || in_valid || expected_px.size() != 0);
  endtask

  // Keys on a random base color and sends a mix of nearby and arbitrary pixels.
  task automatic random_phase(input int count);
    int br;
    int bg;
    int bb;
    int hue;
    int sat;
    int val;
    br = $urandom_range(255);
    bg = $urandom_range(255);
    bb = $urandom_range(255);
    pixel_hsv(br, bg, bb, hue, sat, val);
    if ($urandom_range(5) == 0) hue = $urandom_range(255, 252);
    if ($urandom_range(4) == 0)
      program_key(hue, sat, val, $urandom_range(255), $urandom_range(255), $urandom_range(255));
    else
      program_key(hue, sat, val, $urandom_range(12), $urandom_range(40), $urandom_range(40));
    repeat (count) begin
      if ($urandom_range(99) < 60)
        add_pixel(jitter(br), jitter(bg), jitter(bb),
                  $urandom_range(255), $urandom_range(255), $urandom_range(255));
      else
        add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255), $urandom_range(255));
    end
  endtask

  // Sender: presents the next pending pixel once the current one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_pix.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_pix = pending_pix.pop_front();
        in_valid      <= 1'b1;
        in_red        <= next_pix.red;
        in_green      <= next_pix.green;
        in_blue       <= next_pix.blue;
        in_back_red   <= next_pix.back_red;
        in_back_green <= next_pix.back_green;
        in_back_blue  <= next_pix.back_blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_request && !stall_done) begin
      out_ready <= 1'b0;
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got_px = '{out_red, out_green, out_blue, out_keyed};
        if (expected_px.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("result with no item pending: rgb %0d %0d %0d keyed %0b",
                     got_px.red, got_px.green, got_px.blue, got_px.keyed);
        end else begin
          want_px = expected_px.pop_front();
          if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
              got_px.blue !== want_px.blue || got_px.keyed !== want_px.keyed) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected rgb %0d %0d %0d keyed %0b, got %0d %0d %0d keyed %0b",
                       want_px.red, want_px.green, want_px.blue, want_px.keyed,
                       got_px.red, got_px.green, got_px.blue, got_px.keyed);
          end
        end
      end
      if (in_valid && in_ready)
        expected_px.push_back(predict_key('{in_red, in_green, in_blue, in_back_red,
                                            in_back_green, in_back_blue}, key_set));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset key is saturated green with zero tolerance.
    add_pixel(0, 255, 0, 255, 255, 255);
    add_pixel(0, 254, 0, 0, 0, 0);
    add_pixel(0, 0, 0, 255, 255, 255);
    add_pixel(255, 255, 255, 0, 0, 0);
    add_pixel(128, 128, 128, 1, 2, 3);
    add_pixel(255, 255, 0, 9, 9, 9);
    add_pixel(0, 255, 255, 9, 9, 9);
    add_pixel(255, 0, 255, 9, 9, 9);
    add_pixel(0, 0, 255, 9, 9, 9);
    wait_drained();

    // Writes to unused indexes must leave the key alone.
    write_reg(CFG_SPARE_LO, 8'h5A);
    write_reg(CFG_SPARE_HI, 8'hFF);
    add_pixel(0, 255, 0, 17, 34, 51);
    wait_drained();

    // Key hue near the top of the scale: pure red matches only through the wrap.
    program_key(250, 255, 255, 6, 0, 0);
    add_pixel(255, 0, 0, 255, 255, 255);
    add_pixel(255, 0, 15, 0, 0, 0);
    add_pixel(255, 0, 128, 0, 0, 0);
    add_pixel(255, 40, 0, 0, 0, 0);
    wait_drained();

    // Key hue above 251 is kept as written.
    program_key(255, 0, 0, 3, 255, 255);
    add_pixel(255, 0, 0, 1, 1, 1);
    add_pixel(77, 77, 77, 2, 2, 2);
    add_pixel(0, 255, 0, 3, 3, 3);
    add_pixel(255, 10, 0, 4, 4, 4);
    wait_drained();

    program_key(0, 0, 0, 255, 255, 255);
    add_pixel(0, 0, 0, 255, 0, 255);
    add_pixel(255, 255, 255, 0, 255, 0);
    add_pixel(12, 200, 99, 5, 6, 7);
    wait_drained();

    program_key(0, 0, 0, 0, 0, 0);
    add_pixel(0, 0, 0, 255, 255, 255);
    add_pixel(1, 0, 0, 255, 255, 255);
    add_pixel(0, 0, 1, 255, 255, 255);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (ph == 5) begin
        send_idle_pct = 0;
      end
      random_phase(PHASE_ITEMS);
      if (ph == 5) stall_request = 1'b1;
      wait_drained();
      send_idle_pct = 34;
      recv_idle_pct = 34;
    end

    repeat (NUM_STAGES + 4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/hck_pkg.sv
src/hck_hsv_front.sv
src/hck_div_pipe.sv
src/hck_key_match.sv
src/hsv_chroma_key_pixel.sv
src/hck_checker.sv
sim/tb_top.sv
